// ===== rtl/core/ucf_pkg.sv =====
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared types, constants and code point functions for the UTF-8 to display
// code folder: register indexes, the queue entry, and the letter tables.
// ----------------------------------------------------------------------------
package ucf_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_CAPACITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLD_MODE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PL_CODE_BASE = 2'd2;
   localparam int CSR_DATA_W = 9;

   // reset values
   localparam logic [8:0] OUT_CAPACITY_RESET = 9'd32;
   localparam logic [7:0] PL_CODE_BASE_RESET = 8'd128;

   // largest buffer the count can describe
   localparam logic [8:0] CAPACITY_MAX = 9'd256;

   // queue between decoder and mapper
   localparam int UCF_QUEUE_DEPTH = 2;

   // pending continuation bytes
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   // Polish letters, table order: A-ogonek, C-acute, E-ogonek, L-stroke,
   // N-acute, O-acute, S-acute, Z-acute, Z-dot
   localparam int PL_COUNT = 9;
   localparam logic [15:0] PL_UPPER [PL_COUNT] = '{
      16'h0104, 16'h0106, 16'h0118, 16'h0141, 16'h0143,
      16'h00D3, 16'h015A, 16'h0179, 16'h017B
   };
   localparam logic [15:0] PL_LOWER [PL_COUNT] = '{
      16'h0105, 16'h0107, 16'h0119, 16'h0142, 16'h0144,
      16'h00F3, 16'h015B, 16'h017A, 16'h017C
   };
   localparam logic [7:0] PL_LETTER [PL_COUNT] = '{
      8'h41, 8'h43, 8'h45, 8'h4C, 8'h4E, 8'h4F, 8'h53, 8'h5A, 8'h5A
   };

   // live configuration
   typedef struct packed {
      logic [8:0] out_capacity;
      logic       fold_mode;
      logic [7:0] pl_code_base;
   } ucf_cfg_type;

   // one decoded item travelling from decoder to mapper
   typedef struct packed {
      logic [15:0] point;
      logic        code_valid;
      logic        last;
      logic [7:0]  count;
   } ucf_item_type;

   // Polish letter lookup: bit 4 is the hit, bits 3:0 the table index
   function automatic logic [4:0] pl_lookup(input logic [15:0] cp);
      logic [4:0] res;
      res = 5'd0;
      for (int i = 0; i < PL_COUNT; i++) begin
         if (cp == PL_UPPER[i] || cp == PL_LOWER[i]) begin
            res = {1'b1, 4'(i)};
         end
      end
      return res;
   endfunction

   // Latin-1 accented letters to their base capital, zero if none
   function automatic logic [7:0] latin_fold(input logic [15:0] cp);
      logic [15:0] up;
      logic [7:0]  res;
      up  = (cp >= 16'h00E0 && cp <= 16'h00FE) ? cp - 16'h0020 : cp;
      res = 8'd0;
      if (up >= 16'h00C0 && up <= 16'h00C6) res = 8'h41;
      else if (up == 16'h00C7)                res = 8'h43;
      else if (up >= 16'h00C8 && up <= 16'h00CB) res = 8'h45;
      else if (up >= 16'h00CC && up <= 16'h00CF) res = 8'h49;
      else if (up == 16'h00D1)                res = 8'h4E;
      else if (up >= 16'h00D2 && up <= 16'h00D6) res = 8'h4F;
      else if (up == 16'h00D8)                res = 8'h4F;
      else if (up >= 16'h00D9 && up <= 16'h00DC) res = 8'h55;
      else if (up == 16'h00DD)                res = 8'h59;
      return res;
   endfunction

   // true when the code point yields a display code
   function automatic logic is_drawable(input logic [15:0] cp);
      logic [4:0] pl;
      pl = pl_lookup(cp);
      return (cp != 16'd0 && cp < 16'h0080) || pl[4] || (latin_fold(cp) != 8'd0);
   endfunction

   // display code for a drawable code point
   function automatic logic [7:0] map_point(input logic [15:0] cp,
                                            input logic fold,
                                            input logic [7:0] base);
      logic [4:0] pl;
      logic [7:0] res;
      pl = pl_lookup(cp);
      if (cp >= 16'h0061 && cp <= 16'h007A) begin
         res = cp[7:0] - 8'h20;
      end else if (cp < 16'h0080) begin
         res = cp[7:0];
      end else if (pl[4]) begin
         res = fold ? PL_LETTER[pl[3:0]] : base + {4'd0, pl[3:0]};
      end else begin
         res = latin_fold(cp);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/ucf_front.sv =====
// ----------------------------------------------------------------------------
// ucf_front
// Byte decoder: gathers UTF-8 sequences into code points, tracks the name
// state and the emitted count, and pushes one item per accepted byte.
// ----------------------------------------------------------------------------
module ucf_front
   import ucf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ucf_cfg_type  cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_in_byte,
   input  logic         req_in_last,
   input  logic         queue_full,
   output logic         push_valid,
   output ucf_item_type push_item
);

   logic [1:0]  pending_ff, pending_in;
   logic [15:0] point_ff, point_in;
   logic [7:0]  count_ff, count_in;
   logic        stopped_ff, stopped_in;

   logic        accept;
   logic        handled;
   logic        valid;
   logic [15:0] cp;
   logic [8:0]  cap_eff;
   logic [7:0]  count_next;
   logic [1:0]  pend_w;
   logic [15:0] point_w;
   logic        stop_w;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cap_eff   = (cfg.out_capacity > CAPACITY_MAX) ? CAPACITY_MAX : cfg.out_capacity;

   // decode one byte
   always_comb begin
      handled = 1'b0;
      valid   = 1'b0;
      cp      = 16'd0;
      pend_w  = pending_ff;
      point_w = point_ff;
      stop_w  = stopped_ff;
      if (!stopped_ff) begin
         if (pending_ff != PEND_NONE) begin
            if (req_in_byte[7:6] == 2'b10) begin
               handled = 1'b1;
               if (pending_ff == PEND_TWO) begin
                  point_w = point_ff | {4'd0, req_in_byte[5:0], 6'd0};
                  pend_w  = PEND_ONE;
               end else begin
                  cp      = point_ff | {10'd0, req_in_byte[5:0]};
                  pend_w  = PEND_NONE;
                  point_w = 16'd0;
                  valid   = is_drawable(cp);
               end
            end else begin
               // broken sequence: drop it, retry this byte as a lead
               pend_w  = PEND_NONE;
               point_w = 16'd0;
            end
         end
         if (!handled) begin
            if (req_in_byte == 8'd0 || ({1'b0, count_ff} + 9'd1) >= cap_eff) begin
               stop_w = 1'b1;
            end else if (!req_in_byte[7]) begin
               cp    = {8'd0, req_in_byte};
               valid = 1'b1;
            end else if (req_in_byte[7:5] == 3'b110) begin
               pend_w  = PEND_ONE;
               point_w = {5'd0, req_in_byte[4:0], 6'd0};
            end else if (req_in_byte[7:4] == 4'b1110) begin
               pend_w  = PEND_TWO;
               point_w = {req_in_byte[3:0], 12'd0};
            end
         end
      end
      count_next = valid ? count_ff + 8'd1 : count_ff;
   end

   // next state; a last byte clears everything for the next name
   always_comb begin
      pending_in = pending_ff;
      point_in   = point_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (req_in_last) begin
            pending_in = PEND_NONE;
            point_in   = 16'd0;
            count_in   = 8'd0;
            stopped_in = 1'b0;
         end else begin
            pending_in = pend_w;
            point_in   = point_w;
            count_in   = count_next;
            stopped_in = stop_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         point_ff   <= 16'd0;
         count_ff   <= 8'd0;
         stopped_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         point_ff   <= point_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

   // item toward the mapper
   assign push_valid            = accept;
   assign push_item.point       = cp;
   assign push_item.code_valid  = valid;
   assign push_item.last        = req_in_last;
   assign push_item.count       = count_next;

   a_pending_code: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3) else $error("pending count out of range");

   a_stopped_no_pending: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> pending_ff == PEND_NONE) else $error("stopped with sequence open");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_last |=> count_ff == 8'd0 && !stopped_ff && pending_ff == PEND_NONE)
      else $error("name state not cleared after last byte");

endmodule

// ===== rtl/core/ucf_queue.sv =====
// ----------------------------------------------------------------------------
// ucf_queue
// Short FIFO of decoded items between the decoder and the mapper.
// ----------------------------------------------------------------------------
module ucf_queue
   import ucf_pkg::*;
#(
   parameter int QueueDepth = UCF_QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  ucf_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output ucf_item_type head_item
);

   localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FillW = $clog2(QueueDepth + 1);

   ucf_item_type    entry_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full       = (fill_ff == FillW'(QueueDepth));
   assign head_valid = (fill_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)      fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(QueueDepth)) else $error("queue fill above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full) else $error("item pushed into full queue");

endmodule

// ===== rtl/core/ucf_back.sv =====
// ----------------------------------------------------------------------------
// ucf_back
// Mapper: turns a queued code point into its display code and holds the
// result in an output register until taken.
// ----------------------------------------------------------------------------
module ucf_back
   import ucf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ucf_cfg_type  cfg,
   input  logic         head_valid,
   input  ucf_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_code_valid,
   output logic [7:0]   rsp_code_out,
   output logic         rsp_name_done,
   output logic [7:0]   rsp_code_count
);

   logic       out_valid_ff, out_valid_in;
   logic       code_valid_ff;
   logic [7:0] code_ff, code_in;
   logic       done_ff;
   logic [7:0] count_ff;

   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   // display code for the head item
   always_comb begin
      code_in = head_item.code_valid
              ? map_point(head_item.point, cfg.fold_mode, cfg.pl_code_base) : 8'd0;
      out_valid_in = pop ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         code_valid_ff <= head_item.code_valid;
         code_ff       <= code_in;
         done_ff       <= head_item.last;
         count_ff      <= head_item.count;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_valid = code_valid_ff;
   assign rsp_code_out   = code_ff;
   assign rsp_name_done  = done_ff;
   assign rsp_code_count = count_ff;

   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_code_valid |-> rsp_code_out == 8'd0)
      else $error("dropped item carries a nonzero code");

endmodule

// ===== rtl/core/utf8_to_display_code_folder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_display_code_folder
// Converts a UTF-8 name, one byte per item, into one-byte display codes.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the queue has room and returns exactly one
// result per byte. Each accepted byte is decoded into a short queue and is
// then mapped into the output register that drives rsp_*. Sustained rate
// is one item per cycle as long as rsp_ready is high; the two-entry queue
// and the output register absorb stalls on either side.
// Configuration (out_capacity, fold_mode, pl_code_base) is written through
// csr_write_en / csr_index / csr_wdata and must only change while no item
// is in flight; writes to an index past the last register are ignored.
module utf8_to_display_code_folder
   import ucf_pkg::*;
#(
   parameter int QueueDepth = UCF_QUEUE_DEPTH
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_code_valid,
   output logic [7:0]             rsp_code_out,
   output logic                   rsp_name_done,
   output logic [7:0]             rsp_code_count,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ucf_cfg_type  cfg_ff, cfg_in;
   logic         queue_full;
   logic         push_valid;
   ucf_item_type push_item;
   logic         pop;
   logic         head_valid;
   ucf_item_type head_item;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OUT_CAPACITY: cfg_in.out_capacity = csr_wdata;
            CSR_FOLD_MODE:    cfg_in.fold_mode    = csr_wdata[0];
            CSR_PL_CODE_BASE: cfg_in.pl_code_base = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_capacity <= OUT_CAPACITY_RESET;
         cfg_ff.fold_mode    <= 1'b0;
         cfg_ff.pl_code_base <= PL_CODE_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ucf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   ucf_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ucf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_valid (rsp_code_valid),
      .rsp_code_out   (rsp_code_out),
      .rsp_name_done  (rsp_name_done),
      .rsp_code_count (rsp_code_count)
   );

endmodule
